// File: design/vfi_pkg.sv
`timescale 1ns / 1ps

package vfi_pkg;

   localparam int NUM_AXES = 3;
   localparam int TOL_WIDTH = 31;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } vfi_state_type;

endpackage

// File: design/vertex_find_or_insert_unit.sv
`timescale 1ns / 1ps

// Channel    Ports                                   Transfer
// --------   -------------------------------------   ----------------------------
// request    start, busy, req_point_x/_y/_z          start high while busy low
// response   rsp_valid, rsp_vertex_number,           every cycle rsp_valid is high
//            rsp_created, rsp_table_full
// config     csr_valid, csr_ready, csr_data          csr_valid and csr_ready high
//
// Busy lasts while stored entries are read, one entry per cycle, through the single table
// read port and compared in the single two-stage compare pipeline (table read, registered
// difference), until the first match or, if none matches, until every stored entry is
// compared; the response shows in the first cycle that busy is low. Reset clears the entry
// count and sets the tolerance to one; table contents are kept. The response cannot be
// stalled, and a new point is taken in the cycle its predecessor's response shows.

module vertex_find_or_insert_unit
   import vfi_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   input  logic signed [COORD_WIDTH-1:0]        req_point_z,
   output logic                                 rsp_valid,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_vertex_number,
   output logic                                 rsp_created,
   output logic                                 rsp_table_full,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [TOL_WIDTH-1:0]                 csr_data
);

   localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
   localparam int ENTRY_WIDTH = NUM_AXES * COORD_WIDTH;
   localparam logic [CNT_WIDTH-1:0] DEPTH_COUNT = CNT_WIDTH'(TABLE_DEPTH);

   vfi_state_type state_ff, state_in;

   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [CNT_WIDTH-1:0]   ptr_ff, ptr_in;
   logic [ENTRY_WIDTH-1:0] point_ff, point_in;
   logic [TOL_WIDTH-1:0]   tol_ff, tol_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [ADDR_WIDTH-1:0]  s1_idx_ff, s1_idx_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic [ADDR_WIDTH-1:0]  s2_idx_ff, s2_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_WIDTH-1:0]   rsp_number_ff, rsp_number_in;
   logic                   rsp_created_ff, rsp_created_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   accept;
   logic                   issue;
   logic                   hit;
   logic                   scan_end;
   logic                   decide;
   logic                   wr_en;
   logic                   entry_close;
   logic [ENTRY_WIDTH-1:0] rd_entry;
   logic [ENTRY_WIDTH-1:0] point_ord;

   // Offset-binary form: flipping the sign bit makes unsigned order match signed order.
   assign point_ord = {~req_point_z[COORD_WIDTH-1], req_point_z[COORD_WIDTH-2:0],
                       ~req_point_y[COORD_WIDTH-1], req_point_y[COORD_WIDTH-2:0],
                       ~req_point_x[COORD_WIDTH-1], req_point_x[COORD_WIDTH-2:0]};

   vfi_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_WIDTH-1:0]),
      .wr_data(point_ff),
      .rd_en  (issue),
      .rd_addr(ptr_ff[ADDR_WIDTH-1:0]),
      .rd_data(rd_entry)
   );

   vfi_close_unit #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_close (
      .clock    (clock),
      .point    (point_ff),
      .entry    (rd_entry),
      .tolerance(tol_ff),
      .close    (entry_close)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (decide) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = (state_ff != ST_IDLE);
      accept   = start & (state_ff == ST_IDLE);
      hit      = (state_ff == ST_SCAN) & s2_valid_ff & entry_close;
      scan_end = (state_ff == ST_SCAN) & ~s1_valid_ff & ~s2_valid_ff & (ptr_ff == count_ff);
      decide   = hit | scan_end;
      issue    = (state_ff == ST_SCAN) & (ptr_ff != count_ff) & ~decide;
      wr_en    = scan_end & (count_ff != DEPTH_COUNT);
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (accept) begin
         ptr_in = '0;
      end else if (issue) begin
         ptr_in = ptr_ff + 1'b1;
      end
      point_in    = accept ? point_ord : point_ff;
      count_in    = wr_en ? (count_ff + 1'b1) : count_ff;
      tol_in      = (csr_valid & csr_ready) ? csr_data : tol_ff;
      s1_valid_in = issue;
      s1_idx_in   = ptr_ff[ADDR_WIDTH-1:0];
      s2_valid_in = s1_valid_ff & ~decide;
      s2_idx_in   = s1_idx_ff;

      rsp_valid_in   = decide;
      rsp_created_in = wr_en;
      rsp_full_in    = scan_end & ~wr_en;
      rsp_number_in  = '0;
      if (hit) begin
         rsp_number_in = CNT_WIDTH'(s2_idx_ff) + 1'b1;
      end else if (wr_en) begin
         rsp_number_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= TOL_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      point_ff       <= point_in;
      s1_idx_ff      <= s1_idx_in;
      s2_idx_ff      <= s2_idx_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = rsp_number_ff;
   assign rsp_created       = rsp_created_ff;
   assign rsp_table_full    = rsp_full_ff;

   assert property (@(posedge clock) disable iff (reset) (start & ~busy) |=> busy)
      else $error("accepted point did not make the unit busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> ~busy)
      else $error("response shown while a scan is still running");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0({rsp_created, rsp_table_full}) &&
                     (rsp_table_full == (rsp_vertex_number == '0))))
      else $error("inconsistent response flags");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid & rsp_created) |-> (count_ff == rsp_vertex_number))
      else $error("entry count does not match the newly created vertex number");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (~s1_valid_ff & ~s2_valid_ff))
      else $error("compare pipeline not flushed when idle");

endmodule

// File: design/vfi_table.sv
`timescale 1ns / 1ps

module vfi_table
   import vfi_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int ENTRY_WIDTH = 96
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_WIDTH-1:0]         wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [ENTRY_WIDTH-1:0]         rd_data
);

   logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/vfi_close_unit.sv
`timescale 1ns / 1ps

module vfi_close_unit
   import vfi_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic [NUM_AXES*COORD_WIDTH-1:0]   point,
   input  logic [NUM_AXES*COORD_WIDTH-1:0]   entry,
   input  logic [TOL_WIDTH-1:0]              tolerance,
   output logic                              close
);

   localparam int CMP_WIDTH = (COORD_WIDTH > TOL_WIDTH) ? COORD_WIDTH : TOL_WIDTH;

   logic [COORD_WIDTH-1:0] diff_in [NUM_AXES];
   logic [COORD_WIDTH-1:0] diff_ff [NUM_AXES];
   logic [NUM_AXES-1:0]    axis_close;

   // Both operands are in offset-binary form, so unsigned order is signed order.
   always_comb begin
      logic [COORD_WIDTH-1:0] a;
      logic [COORD_WIDTH-1:0] b;
      for (int i = 0; i < NUM_AXES; i++) begin
         a = point[i*COORD_WIDTH +: COORD_WIDTH];
         b = entry[i*COORD_WIDTH +: COORD_WIDTH];
         diff_in[i] = (a >= b) ? (a - b) : (b - a);
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         axis_close[i] = CMP_WIDTH'(diff_ff[i]) <= CMP_WIDTH'(tolerance);
      end
   end

   assign close = &axis_close;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import vfi_pkg::*;

   localparam int DEPTH = 256;
   localparam int CW = 32;
   localparam int NUM_W = $clog2(DEPTH + 1);
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_POINTS = 235;
   localparam logic [TOL_WIDTH-1:0] TOL_MAX = '1;
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_ONE = 32'sh0001_0000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic [NUM_W-1:0] number;
      logic             created;
      logic             full;
   } weld_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   coord_type            req_point_x;
   coord_type            req_point_y;
   coord_type            req_point_z;
   logic                 rsp_valid;
   logic [NUM_W-1:0]     rsp_vertex_number;
   logic                 rsp_created;
   logic                 rsp_table_full;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [TOL_WIDTH-1:0] csr_data;

   logic [TOL_WIDTH-1:0] tolerance_model;
   coord_type            vertex_x [DEPTH];
   coord_type            vertex_y [DEPTH];
   coord_type            vertex_z [DEPTH];
   int                   vertex_count;
   weld_result_type      pending_welds [$];
   weld_result_type      oldest_weld;
   int                   error_count;
   int                   idle_cycles;
   bit                   steady;

   vertex_find_or_insert_unit #(
      .TABLE_DEPTH(DEPTH),
      .COORD_WIDTH(CW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_point_z(req_point_z),
      .rsp_valid(rsp_valid),
      .rsp_vertex_number(rsp_vertex_number),
      .rsp_created(rsp_created),
      .rsp_table_full(rsp_table_full),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic bit axis_near(coord_type a, coord_type b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d <= longint'(tolerance_model);
   endfunction

   function automatic weld_result_type predict_weld(coord_type x, coord_type y,
                                                    coord_type z);
      weld_result_type r;
      int hit;
      hit = -1;
      for (int i = 0; i < vertex_count; i++) begin
         if (hit < 0 && axis_near(x, vertex_x[i]) && axis_near(y, vertex_y[i]) &&
             axis_near(z, vertex_z[i])) hit = i;
      end
      r = '0;
      if (hit >= 0) begin
         r.number = NUM_W'(hit + 1);
      end else if (vertex_count == DEPTH) begin
         r.full = 1'b1;
      end else begin
         vertex_x[vertex_count] = x;
         vertex_y[vertex_count] = y;
         vertex_z[vertex_count] = z;
         vertex_count++;
         r.number = NUM_W'(vertex_count);
         r.created = 1'b1;
      end
      return r;
   endfunction

   function automatic coord_type nudge(coord_type base);
      longint tol;
      longint off;
      longint sum;
      tol = longint'(tolerance_model);
      if ($urandom_range(0, 9) < 7)
         off = (tol == 0) ? 0 : longint'($urandom_range(0, int'(tol)));
      else
         off = tol + 1;
      if ($urandom_range(0, 1) == 1) off = -off;
      sum = longint'(base) + off;
      return sum[CW-1:0];
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return -1;
         4: return 1;
         default: return COORD_ONE;
      endcase
   endfunction

   function automatic void pick_point(output coord_type x, output coord_type y,
                                      output coord_type z);
      int mode;
      int k;
      mode = $urandom_range(0, 99);
      k = (vertex_count > 0) ? $urandom_range(0, vertex_count - 1) : 0;
      if (vertex_count == 0 || mode < 35) begin
         x = $urandom;
         y = $urandom;
         z = $urandom;
      end else if (mode < 75) begin
         x = nudge(vertex_x[k]);
         y = nudge(vertex_y[k]);
         z = nudge(vertex_z[k]);
      end else if (mode < 85) begin
         x = vertex_x[k];
         y = vertex_y[k];
         z = vertex_z[k];
      end else if (mode < 95) begin
         x = corner_coord();
         y = corner_coord();
         z = corner_coord();
      end else begin
         x = int'($urandom_range(0, 16)) - 8;
         y = int'($urandom_range(0, 16)) - 8;
         z = int'($urandom_range(0, 16)) - 8;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_point(coord_type x, coord_type y, coord_type z);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 34) gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (busy);
      pending_welds.push_back(predict_weld(x, y, z));
   endtask

   task automatic send_random_point();
      coord_type x;
      coord_type y;
      coord_type z;
      pick_point(x, y, z);
      send_point(x, y, z);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_welds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_WIDTH-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tolerance_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_tolerance();
      send_point(0, 0, 0);
      send_point(1, -1, 1);
      send_point(2, 0, 0);
      send_point(1, 0, 0);
      send_point(0, 0, 2);
      send_point(0, 2, 0);
   endtask

   task automatic test_coordinate_extremes();
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MAX - 1, COORD_MAX, COORD_MAX - 1);
      send_point(COORD_MIN + 1, COORD_MIN, COORD_MIN + 1);
      send_point(-1, -1, -1);
      send_point(COORD_MIN, COORD_MIN, COORD_MAX);
   endtask

   task automatic test_tolerance_extremes();
      write_tolerance(TOL_MAX);
      send_point(0, 0, 0);
      send_point(COORD_MAX, COORD_MIN, 0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      write_tolerance('0);
      send_point(1, 0, 0);
      send_point(0, 0, 0);
      send_point(COORD_ONE, -COORD_ONE, COORD_ONE);
      send_point(COORD_ONE, -COORD_ONE, COORD_ONE);
   endtask

   task automatic test_tolerance_sweep();
      logic [TOL_WIDTH-1:0] setting [7];
      setting[0] = TOL_WIDTH'(1);
      setting[1] = '0;
      setting[2] = TOL_WIDTH'($urandom_range(0, 65536));
      setting[3] = TOL_MAX;
      setting[4] = TOL_WIDTH'($urandom);
      setting[5] = COORD_ONE[TOL_WIDTH-1:0];
      setting[6] = TOL_WIDTH'($urandom_range(0, 1 << 20));
      foreach (setting[p]) begin
         write_tolerance(setting[p]);
         steady = (p == 3);
         repeat (PHASE_POINTS) send_random_point();
      end
      steady = 1'b0;
   endtask

   task automatic test_table_full();
      int k;
      write_tolerance('0);
      while (vertex_count < DEPTH) send_point($urandom, $urandom, $urandom);
      repeat (30) begin
         if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, DEPTH - 1);
            send_point(vertex_x[k], vertex_y[k], vertex_z[k]);
         end else begin
            send_point($urandom, $urandom, $urandom);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_welds.size() == 0) begin
            report_mismatch("response with no point outstanding",
                            int'(rsp_vertex_number), 0);
         end else begin
            oldest_weld = pending_welds.pop_front();
            if (rsp_vertex_number !== oldest_weld.number)
               report_mismatch("vertex_number", int'(rsp_vertex_number),
                               int'(oldest_weld.number));
            if (rsp_created !== oldest_weld.created)
               report_mismatch("created", int'(rsp_created), int'(oldest_weld.created));
            if (rsp_table_full !== oldest_weld.full)
               report_mismatch("table_full", int'(rsp_table_full), int'(oldest_weld.full));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("vertex_find_or_insert_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      tolerance_model = TOL_RESET;
      vertex_count = 0;
      error_count = 0;
      idle_cycles = 0;
      steady = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_tolerance();
      test_coordinate_extremes();
      test_tolerance_extremes();
      test_tolerance_sweep();
      test_table_full();
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("vertex_find_or_insert_unit: match");
      else
         $display("vertex_find_or_insert_unit: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
design/vfi_pkg.sv
design/vfi_table.sv
design/vfi_close_unit.sv
design/vertex_find_or_insert_unit.sv
tb/sv/tb.sv
